// ===== hw/rtl/sac_pkg.sv =====
package sac_pkg;

  // Classified request operations
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_DROP  = 2'd3
  } op_t;

  // Input mode codes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;

  // Result kind codes
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [2:0] MAX_LEN = 3'd4;

  // One classified request held in the queue
  typedef struct packed {
    op_t         op;
    logic [31:0] address;
    logic [2:0]  length;
    logic [31:0] write_data;
    logic [31:0] fill_data;
  } item_t;

  // Control from the back part to the front part
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

// ===== hw/rtl/sac_ram.sv =====
module sac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/sac_front.sv =====
module sac_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [31:0]        address,
  input  logic [2:0]         length,
  input  logic [31:0]        write_data,
  input  logic [31:0]        fill_data,
  input  sac_pkg::back_ctl_t ctl,
  output logic               q_valid,
  output sac_pkg::item_t     q_item
);
  import sac_pkg::*;

  item_t      cls;
  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // Classify the incoming request
  always_comb begin
    cls.address    = address;
    cls.write_data = write_data;
    cls.fill_data  = fill_data;
    cls.length     = (length > MAX_LEN) ? MAX_LEN : length;
    case (mode)
      MODE_READ:  cls.op = (length == 3'd0) ? OP_DROP : OP_READ;
      MODE_WRITE: cls.op = (length == 3'd0) ? OP_DROP : OP_WRITE;
      MODE_FILL:  cls.op = OP_FILL;
      default:    cls.op = OP_DROP;
    endcase
  end

  assign in_stall = (count == 2'd2) || ctl.clearing;
  assign push     = in_valid && !in_stall;
  assign pop      = ctl.pop && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  // Hold classified requests in a two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/sac_back.sv =====
module sac_back #(
  parameter int SET_BITS        = 7,
  parameter int WAY_BITS        = 3,
  parameter int BLOCK_BYTE_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  sac_pkg::item_t     q_item,
  output sac_pkg::back_ctl_t ctl,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [31:0]        out_address,
  output logic [2:0]         out_length,
  output logic [31:0]        out_data,
  output logic               was_hit,
  output logic [31:0]        hit_count,
  output logic [31:0]        miss_count,
  output logic               last_of_run
);
  import sac_pkg::*;

  localparam int NSETS     = 1 << SET_BITS;
  localparam int NWAYS     = 1 << WAY_BITS;
  localparam int BLK       = 1 << BLOCK_BYTE_BITS;
  localparam int WORD_BITS = BLOCK_BYTE_BITS - 2;
  localparam int NWORDS    = 1 << WORD_BITS;
  localparam int TAG_W     = 32 - SET_BITS - BLOCK_BYTE_BITS;
  localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int FC_W      = (WORD_BITS > 0) ? WORD_BITS : 1;
  localparam int DADDR_W   = SET_BITS + WAY_BITS + WORD_BITS;
  localparam int ROOM_W    = BLOCK_BYTE_BITS + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_DATA  = 7'b0100000,
    S_FILL  = 7'b1000000
  } state_t;

  state_t               state;
  logic [SET_BITS-1:0]  clr_idx;
  op_t                  op_q;
  logic [31:0]          base;
  logic [2:0]           len_q;
  logic [31:0]          wdata_q;
  logic [2:0]           done;
  logic [31:0]          partial;
  logic                 missed;
  logic [31:0]          part_addr;
  logic [2:0]           part_n;
  logic [WAY_W-1:0]     way_q;
  logic [FC_W-1:0]      fill_cnt;
  logic [31:0]          hit_cnt;
  logic [31:0]          miss_cnt;

  logic                 can_emit;
  logic [31:0]          a_look;
  logic [2:0]           rem;
  logic [ROOM_W-1:0]    room;
  logic [2:0]           n_look;
  logic [SET_BITS-1:0]  set_look;
  logic [SET_BITS-1:0]  set_part;
  logic [TAG_W-1:0]     tag_part;
  logic [BLOCK_BYTE_BITS-1:0] off;
  logic [NWAYS-1:0]     valid_rd;
  logic [NWAYS-1:0]     valid_wr;
  logic [NWAYS*TAG_W-1:0] tag_rd;
  logic [NWAYS*TAG_W-1:0] tag_wr;
  logic [NWAYS-1:0]     match;
  logic                 hit;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     victim;
  logic [WAY_W-1:0]     lane_way;
  logic [2:0]           done_n;
  logic                 last_part;
  logic [31:0]          bytes;
  logic [31:0]          gathered;
  logic [5:0]           mask_sh;
  logic [SET_BITS-1:0]  meta_addr;
  logic                 meta_we;
  logic                 clear_we;
  logic                 wr_hit_we;
  logic                 fill_we;
  logic                 emit;
  logic [1:0]           e_kind;
  logic [31:0]          e_addr;
  logic [2:0]           e_len;
  logic [31:0]          e_data;
  logic                 e_hit;
  logic [31:0]          hit_cnt_n;
  logic [31:0]          miss_cnt_n;
  logic                 e_last;

  logic [DADDR_W-1:0]   lane_addr [4];
  logic [7:0]           lane_wdata [4];
  logic                 lane_we [4];
  logic [7:0]           lane_rd [4];
  logic [1:0]           lane_j [4];
  logic                 lane_act [4];

  assign can_emit = !out_valid || !out_stall;

  // Split off the next part of the access at the block boundary
  assign a_look   = base + {29'd0, done};
  assign rem      = len_q - done;
  assign room     = ROOM_W'(BLK) - {1'b0, a_look[BLOCK_BYTE_BITS-1:0]};
  assign n_look   = ({{(ROOM_W-3){1'b0}}, rem} < room) ? rem : room[2:0];
  assign set_look = a_look[BLOCK_BYTE_BITS +: SET_BITS];
  assign set_part = part_addr[BLOCK_BYTE_BITS +: SET_BITS];
  assign tag_part = part_addr[31 -: TAG_W];
  assign off      = part_addr[BLOCK_BYTE_BITS-1:0];
  assign done_n   = done + part_n;
  assign last_part = (done_n == len_q);

  // Compare tags, pick hit way and victim
  always_comb begin
    hit_way = '0;
    victim  = '0;
    for (int w = NWAYS - 1; w >= 0; w--) begin
      match[w] = valid_rd[w] && (tag_rd[w*TAG_W +: TAG_W] == tag_part);
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_rd[w]) begin
        victim = WAY_W'(w);
      end
    end
    hit = |match;
  end

  always_comb begin
    tag_wr = tag_rd;
    tag_wr[victim*TAG_W +: TAG_W] = tag_part;
    valid_wr = valid_rd | (NWAYS'(1) << victim);
  end

  // Align the write bytes of this part
  assign mask_sh = 6'd32 - {part_n, 3'b000};
  assign bytes   = (wdata_q >> {done, 3'b000}) & (32'hFFFF_FFFF >> mask_sh);

  assign lane_way  = (state == S_CMP) ? hit_way : way_q;
  assign wr_hit_we = (state == S_CMP) && (op_q == OP_WRITE) && hit && can_emit;
  assign fill_we   = (state == S_FILL) && q_valid && (q_item.op == OP_FILL);

  // Map bytes of the part onto the four byte lanes
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_j[l]   = 2'(l) - off[1:0];
      lane_act[l] = ({1'b0, lane_j[l]} < part_n);
      if (fill_we) begin
        lane_addr[l] = DADDR_W'((32'(set_part) << (WAY_BITS + WORD_BITS))
                     | (32'(way_q) << WORD_BITS) | 32'(fill_cnt));
        lane_wdata[l] = q_item.fill_data[8*l +: 8];
        lane_we[l]    = 1'b1;
      end else begin
        lane_addr[l] = DADDR_W'((32'(set_part) << (WAY_BITS + WORD_BITS))
                     | (32'(lane_way) << WORD_BITS)
                     | (((32'(off) + 32'(lane_j[l])) >> 2) & 32'(NWORDS - 1)));
        lane_wdata[l] = bytes[8*lane_j[l] +: 8];
        lane_we[l]    = wr_hit_we && lane_act[l];
      end
    end
  end

  // Join the read bytes of this part little-endian
  always_comb begin
    logic [1:0] l;
    gathered = partial;
    for (int j = 0; j < 4; j++) begin
      l = off[1:0] + 2'(j);
      if (3'(j) < part_n) begin
        gathered = gathered | (32'(lane_rd[l]) << (5'(done + 3'(j)) << 3));
      end
    end
  end

  genvar gl;
  generate
    for (gl = 0; gl < 4; gl++) begin : g_lane
      sac_ram #(
        .WIDTH (8),
        .DEPTH (1 << DADDR_W)
      ) u_data (
        .clk   (clk),
        .we    (lane_we[gl]),
        .addr  (lane_addr[gl]),
        .wdata (lane_wdata[gl]),
        .rdata (lane_rd[gl])
      );
    end
  endgenerate

  // Tag and valid rows, one per set
  assign clear_we  = (state == S_CLEAR);
  assign meta_we   = (state == S_CMP) && (op_q == OP_READ) && !hit && can_emit;
  assign meta_addr = (state == S_LOOK) ? set_look : (clear_we ? clr_idx : set_part);

  sac_ram #(
    .WIDTH (NWAYS),
    .DEPTH (NSETS)
  ) u_valid (
    .clk   (clk),
    .we    (clear_we || meta_we),
    .addr  (meta_addr),
    .wdata (clear_we ? '0 : valid_wr),
    .rdata (valid_rd)
  );

  sac_ram #(
    .WIDTH (NWAYS * TAG_W),
    .DEPTH (NSETS)
  ) u_tag (
    .clk   (clk),
    .we    (meta_we),
    .addr  (meta_addr),
    .wdata (tag_wr),
    .rdata (tag_rd)
  );

  assign ctl.pop      = q_valid && ((state == S_IDLE) || (state == S_FILL));
  assign ctl.clearing = (state == S_CLEAR);

  // Choose the result to emit this cycle
  always_comb begin
    emit       = 1'b0;
    e_kind     = KIND_READ;
    e_addr     = base;
    e_len      = len_q;
    e_data     = gathered;
    e_hit      = !missed;
    e_last     = 1'b1;
    hit_cnt_n  = hit_cnt;
    miss_cnt_n = miss_cnt;
    case (state)
      S_CMP: begin
        if (op_q == OP_WRITE) begin
          emit   = can_emit;
          e_kind = KIND_WRITE;
          e_addr = part_addr;
          e_len  = part_n;
          e_data = bytes;
          e_hit  = hit;
          e_last = last_part;
          if (hit) begin
            hit_cnt_n = hit_cnt + 32'd1;
          end else begin
            miss_cnt_n = miss_cnt + 32'd1;
          end
        end else if (hit) begin
          hit_cnt_n = hit_cnt + 32'd1;
        end else begin
          emit       = can_emit;
          e_kind     = KIND_FILL;
          e_addr     = part_addr & ~32'(BLK - 1);
          e_len      = 3'd0;
          e_data     = 32'd0;
          e_hit      = 1'b0;
          miss_cnt_n = miss_cnt + 32'd1;
        end
      end
      S_DATA: begin
        emit = last_part && can_emit;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequence the parts of each request
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      hit_cnt  <= 32'd0;
      miss_cnt <= 32'd0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_BITS'(NSETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && ((q_item.op == OP_READ) || (q_item.op == OP_WRITE))) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (op_q == OP_WRITE) begin
            if (can_emit) begin
              hit_cnt  <= hit_cnt_n;
              miss_cnt <= miss_cnt_n;
              state    <= last_part ? S_IDLE : S_LOOK;
            end
          end else if (hit) begin
            hit_cnt <= hit_cnt_n;
            state   <= S_RD;
          end else if (can_emit) begin
            miss_cnt <= miss_cnt_n;
            state    <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_we && (fill_cnt == FC_W'(NWORDS - 1))) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (!last_part) begin
            state <= S_LOOK;
          end else if (can_emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request context
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q    <= q_item.op;
        base    <= q_item.address;
        len_q   <= q_item.length;
        wdata_q <= q_item.write_data;
        done    <= 3'd0;
        partial <= 32'd0;
        missed  <= 1'b0;
      end
      S_LOOK: begin
        part_addr <= a_look;
        part_n    <= n_look;
      end
      S_CMP: begin
        if (op_q == OP_WRITE) begin
          if (can_emit) begin
            done <= done_n;
          end
        end else if (hit) begin
          way_q <= hit_way;
        end else if (can_emit) begin
          way_q    <= victim;
          missed   <= 1'b1;
          fill_cnt <= '0;
        end
      end
      S_FILL: begin
        if (fill_we) begin
          fill_cnt <= (fill_cnt == FC_W'(NWORDS - 1)) ? '0 : fill_cnt + 1'b1;
        end
      end
      S_DATA: begin
        if (!last_part) begin
          partial <= gathered;
          done    <= done_n;
        end
      end
      default: begin
        done <= done;
      end
    endcase
  end

  // Drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= e_kind;
      out_address <= e_addr;
      out_length  <= e_len;
      out_data    <= e_data;
      was_hit     <= e_hit;
      hit_count   <= hit_cnt_n;
      miss_count  <= miss_cnt_n;
      last_of_run <= e_last;
    end
  end

endmodule

// ===== hw/rtl/set_assoc_write_through_cache_unit.sv =====
// Set-associative write-through, no-write-allocate data cache.
// Request channel: in_valid/in_stall with mode, address, length, write_data
// and fill_data; a request is taken when in_valid is high and in_stall low.
// Mode read or write starts an access of 1 to 4 bytes; mode fill delivers one
// 32-bit block word from the next level while a read miss waits.
// Result channel: out_valid/out_stall with kind, out_address, out_length,
// out_data, was_hit, hit_count, miss_count and last_of_run.
// A two-entry queue sits between request intake and the lookup sequencer.
// Each part of an access goes through a tag-row read and a compare; a read
// part adds a data read and the join, and each request starts with a step in
// the idle state; the tag and data memories are single-ported. A read miss
// emits a fill request, then waits for one block of fill words (16 by
// default) before the read continues.
// After reset the valid rows are cleared, one set a cycle; in_stall stays
// high until then and the internal hit and miss counters start from zero.
// When out_stall is high the result register holds and the sequencer waits
// before it emits again; requests keep queueing until the queue is full.
module set_assoc_write_through_cache_unit #(
  parameter int SET_BITS        = 7,
  parameter int WAY_BITS        = 3,
  parameter int BLOCK_BYTE_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic [2:0]  length,
  input  logic [31:0] write_data,
  input  logic [31:0] fill_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] out_address,
  output logic [2:0]  out_length,
  output logic [31:0] out_data,
  output logic        was_hit,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count,
  output logic        last_of_run
);
  import sac_pkg::*;

  logic      q_valid;
  item_t     q_item;
  back_ctl_t ctl;

  sac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .address    (address),
    .length     (length),
    .write_data (write_data),
    .fill_data  (fill_data),
    .ctl        (ctl),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  sac_back #(
    .SET_BITS        (SET_BITS),
    .WAY_BITS        (WAY_BITS),
    .BLOCK_BYTE_BITS (BLOCK_BYTE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_address (out_address),
    .out_length  (out_length),
    .out_data    (out_data),
    .was_hit     (was_hit),
    .hit_count   (hit_count),
    .miss_count  (miss_count),
    .last_of_run (last_of_run)
  );

endmodule

// ===== hw/rtl/sac_checker.sv =====
module sac_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [31:0] out_address,
  input logic [2:0]  out_length,
  input logic [31:0] out_data,
  input logic        was_hit,
  input logic [31:0] hit_count,
  input logic [31:0] miss_count,
  input logic        last_of_run
);
  import sac_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_address)
      && $stable(out_length) && $stable(out_data) && $stable(was_hit)
      && $stable(hit_count) && $stable(miss_count) && $stable(last_of_run))
    else $error("stalled result changed");

  // No result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // Fill request carries a block address and no data
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FILL) |->
      (out_length == 3'd0) && (out_data == 32'd0) && !was_hit && last_of_run)
    else $error("malformed fill request");

  // Read data ends its request and never exceeds four bytes
  a_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_READ) |->
      last_of_run && (out_length != 3'd0) && (out_length <= MAX_LEN))
    else $error("malformed read result");

endmodule

bind set_assoc_write_through_cache_unit sac_checker u_sac_checker (.*);
